### hw/rtl/ppst_pkg.sv
// ----------------------------------------------------------------------------
// ppst_pkg: shared types and constants for pure pursuit steering
// Fixed point formats, register map codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ppst_pkg;

  localparam int CORDIC_STEPS = 20;

  localparam int CFG_W   = 23;
  localparam int COORD_W = 24;
  localparam int DX_W    = 25;
  localparam int DIST_W  = 24;
  localparam int ANGLE_W = 18;

  localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 18'sd102944;

  // register map, word index
  localparam logic [2:0] REG_LOOKAHEAD_REQUEST = 3'd0;
  localparam logic [2:0] REG_LOOKAHEAD_MIN     = 3'd1;
  localparam logic [2:0] REG_LOOKAHEAD_MAX     = 3'd2;
  localparam logic [2:0] REG_VEHICLE_LENGTH    = 3'd3;
  localparam logic [2:0] REG_FORWARD_OFFSET    = 3'd4;
  localparam logic [2:0] REG_DISTANCE_MARGIN   = 3'd5;

  typedef struct packed {
    logic [CFG_W-1:0]          lfd;
    logic [CFG_W-1:0]          vehicle_length;
    logic signed [COORD_W-1:0] forward_offset;
    logic [CFG_W-1:0]          distance_margin;
  } cfg_t;

  // atan(2^-i) in Q2.30
  function automatic logic [30:0] atan_q30(input logic [4:0] i);
    logic [30:0] v;
    case (i)
      5'd0:  v = 31'd843314857;
      5'd1:  v = 31'd497837829;
      5'd2:  v = 31'd263043837;
      5'd3:  v = 31'd133525159;
      5'd4:  v = 31'd67021687;
      5'd5:  v = 31'd33543516;
      5'd6:  v = 31'd16775851;
      5'd7:  v = 31'd8388437;
      5'd8:  v = 31'd4194283;
      5'd9:  v = 31'd2097149;
      5'd10: v = 31'd1048576;
      5'd11: v = 31'd524288;
      5'd12: v = 31'd262144;
      5'd13: v = 31'd131072;
      5'd14: v = 31'd65536;
      5'd15: v = 31'd32768;
      5'd16: v = 31'd16384;
      5'd17: v = 31'd8192;
      5'd18: v = 31'd4096;
      5'd19: v = 31'd2048;
      5'd20: v = 31'd1024;
      5'd21: v = 31'd512;
      5'd22: v = 31'd256;
      5'd23: v = 31'd128;
      5'd24: v = 31'd64;
      5'd25: v = 31'd32;
      5'd26: v = 31'd16;
      5'd27: v = 31'd8;
      5'd28: v = 31'd4;
      5'd29: v = 31'd2;
      5'd30: v = 31'd1;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/ppst_core.sv
// ----------------------------------------------------------------------------
// ppst_core: sequenced datapath for pure pursuit steering
// Shared multiplier, bit serial square root and divider, CORDIC vectoring.
// ----------------------------------------------------------------------------
module ppst_core (
  input  logic                           clk,
  input  logic                           rst,
  input  ppst_pkg::cfg_t                 cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [ppst_pkg::COORD_W-1:0] px,
  input  logic signed [ppst_pkg::COORD_W-1:0] py,
  input  logic                           plast,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [ppst_pkg::ANGLE_W-1:0] angle,
  output logic                           found_out,
  output logic [ppst_pkg::DIST_W-1:0]    dist_out
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ1  = 4'd1;
  localparam logic [3:0] S_SQ2  = 4'd2;
  localparam logic [3:0] S_SQRT = 4'd3;
  localparam logic [3:0] S_CMP  = 4'd4;
  localparam logic [3:0] S_END  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_MUL  = 4'd7;
  localparam logic [3:0] S_NUM  = 4'd8;
  localparam logic [3:0] S_CORD = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  localparam logic [4:0] CORD_LAST = 5'(ppst_pkg::CORDIC_STEPS - 1);

  logic [3:0]                        state;
  logic                              found;
  logic                              last;
  logic signed [ppst_pkg::DX_W-1:0]  dx;
  logic signed [ppst_pkg::COORD_W-1:0] dy;
  logic [ppst_pkg::DIST_W-1:0]       hold_dist;
  logic [24:0]                       hold_r;
  logic [49:0]                       rad;
  logic [49:0]                       res;
  logic [4:0]                        cnt;
  logic [24:0]                       rem;
  logic [16:0]                       quo;
  logic signed [43:0]                cx;
  logic signed [43:0]                cy;
  logic signed [32:0]                cz;
  logic signed [ppst_pkg::ANGLE_W-1:0] ang;

  logic signed [24:0] mul_a, mul_b;
  logic signed [49:0] mul_p;
  logic signed [ppst_pkg::DX_W-1:0] dx_in;
  logic [49:0] sq_bit, sq_t;
  logic [23:0] ay;
  logic [25:0] rem2;
  logic [40:0] num_mag;
  logic signed [43:0] cxs, cys;
  logic signed [32:0] z_atan;
  logic signed [18:0] z_rnd;

  always_comb begin
    case (state)
      S_SQ1: begin
        mul_a = dx;
        mul_b = dx;
      end
      S_SQ2: begin
        mul_a = 25'(dy);
        mul_b = 25'(dy);
      end
      default: begin
        mul_a = {2'b00, cfg.vehicle_length};
        mul_b = {8'd0, quo};
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign dx_in   = 25'(px) + 25'(cfg.forward_offset);
  assign sq_bit  = 50'd1 << {cnt, 1'b0};
  assign sq_t    = res + sq_bit;
  assign ay      = dy[23] ? 24'(-dy) : 24'(dy);
  assign rem2    = {rem, (cnt == 5'd16) ? ay[0] : 1'b0};
  assign num_mag = {rad[39:0], 1'b0};
  assign cxs     = cx >>> cnt;
  assign cys     = cy >>> cnt;
  assign z_atan  = 33'({2'b00, ppst_pkg::atan_q30(cnt)});
  assign z_rnd   = 19'((cz + 33'sd8192) >>> 14);

  always_comb begin
    if (z_rnd > 19'(ppst_pkg::ANGLE_LIMIT)) begin
      ang = ppst_pkg::ANGLE_LIMIT;
    end else if (z_rnd < -19'(ppst_pkg::ANGLE_LIMIT)) begin
      ang = -ppst_pkg::ANGLE_LIMIT;
    end else begin
      ang = 18'(z_rnd);
    end
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      found     <= 1'b0;
      hold_dist <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FIN && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            last <= plast;
            if (!found) begin
              dx <= dx_in;
              dy <= py;
              state <= (dx_in > 25'sd0) ? S_SQ1 : S_END;
            end else begin
              state <= S_END;
            end
          end
        end
        S_SQ1: begin
          rad   <= 50'(mul_p);
          state <= S_SQ2;
        end
        S_SQ2: begin
          rad   <= rad + 50'(mul_p);
          res   <= '0;
          cnt   <= 5'd24;
          state <= S_SQRT;
        end
        S_SQRT: begin
          // one result bit per step
          if (rad >= sq_t) begin
            rad <= rad - sq_t;
            res <= (res >> 1) + sq_bit;
          end else begin
            res <= res >> 1;
          end
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          hold_r    <= res[24:0];
          hold_dist <= res[24] ? {ppst_pkg::DIST_W{1'b1}} : res[23:0];
          if ((25'(res[24] ? {ppst_pkg::DIST_W{1'b1}} : res[23:0])
               + 25'(cfg.distance_margin)) >= 25'(cfg.lfd)) begin
            found <= 1'b1;
          end
          state <= S_END;
        end
        S_END: begin
          if (!last) begin
            state <= S_IDLE;
          end else if (found) begin
            rem   <= 25'(ay >> 1);
            quo   <= '0;
            cnt   <= 5'd16;
            state <= S_DIV;
          end else begin
            cz    <= '0;
            state <= S_FIN;
          end
        end
        S_DIV: begin
          // restoring division, sine = |dy| * 2^16 / r
          if (rem2 >= {1'b0, hold_r}) begin
            rem <= 25'(rem2 - {1'b0, hold_r});
            quo <= {quo[15:0], 1'b1};
          end else begin
            rem <= rem2[24:0];
            quo <= {quo[15:0], 1'b0};
          end
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          rad   <= 50'(mul_p);
          state <= S_NUM;
        end
        S_NUM: begin
          cy  <= dy[23] ? -44'(num_mag) : 44'(num_mag);
          cx  <= {5'd0, cfg.lfd, 16'd0};
          cz  <= '0;
          cnt <= '0;
          state <= (num_mag == 41'd0) ? S_FIN : S_CORD;
        end
        S_CORD: begin
          if (!cy[43]) begin
            cx <= cx + cys;
            cy <= cy - cxs;
            cz <= cz + z_atan;
          end else begin
            cx <= cx - cys;
            cy <= cy + cxs;
            cz <= cz - z_atan;
          end
          cnt <= cnt + 5'd1;
          if (cnt == CORD_LAST) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            angle     <= ang;
            found_out <= found;
            dist_out  <= hold_dist;
            found     <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/pure_pursuit_steering.sv
// ----------------------------------------------------------------------------
// pure_pursuit_steering: look-ahead point search and steering angle
// Register file on an APB-style port and the sequenced steering datapath.
// ----------------------------------------------------------------------------
// sequence: items with x <= 0 or after a find skip the search, others are
//   squared, rooted and compared; a closing item goes to output, after a find
//   via a 17-step divide, multiply and 20 cordic steps (none if numerator is 0)
// throughput: one item at a time; the sqrt, divide and cordic loops set it
// reset: sync active high, registers take their documented defaults, no
//   result pending, found flag and held distance cleared
module pure_pursuit_steering (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [4:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ppst_pkg::COORD_W-1:0] point_x,
  input  logic signed [ppst_pkg::COORD_W-1:0] point_y,
  input  logic                                last_point,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ppst_pkg::ANGLE_W-1:0] steer_angle,
  output logic                                point_found,
  output logic [ppst_pkg::DIST_W-1:0]         tracked_distance
);

  // configuration registers
  logic [ppst_pkg::CFG_W-1:0]          lookahead_request;
  logic [ppst_pkg::CFG_W-1:0]          lookahead_min;
  logic [ppst_pkg::CFG_W-1:0]          lookahead_max;
  logic [ppst_pkg::CFG_W-1:0]          vehicle_length;
  logic signed [ppst_pkg::COORD_W-1:0] forward_offset;
  logic [ppst_pkg::CFG_W-1:0]          distance_margin;

  logic           wr_en;
  logic [2:0]     reg_idx;
  ppst_pkg::cfg_t cfg;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      lookahead_request <= 23'd32768;
      lookahead_min     <= 23'd19661;
      lookahead_max     <= 23'd111411;
      vehicle_length    <= 23'd22938;
      forward_offset    <= 24'sd32768;
      distance_margin   <= 23'd0;
    end else if (wr_en) begin
      case (reg_idx)
        ppst_pkg::REG_LOOKAHEAD_REQUEST: lookahead_request <= pwdata[22:0];
        ppst_pkg::REG_LOOKAHEAD_MIN:     lookahead_min     <= pwdata[22:0];
        ppst_pkg::REG_LOOKAHEAD_MAX:     lookahead_max     <= pwdata[22:0];
        ppst_pkg::REG_VEHICLE_LENGTH:    vehicle_length    <= pwdata[22:0];
        ppst_pkg::REG_FORWARD_OFFSET:    forward_offset    <= pwdata[23:0];
        ppst_pkg::REG_DISTANCE_MARGIN:   distance_margin   <= pwdata[22:0];
        default: ;  // writes outside the map are dropped
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      ppst_pkg::REG_LOOKAHEAD_REQUEST: prdata = {9'd0, lookahead_request};
      ppst_pkg::REG_LOOKAHEAD_MIN:     prdata = {9'd0, lookahead_min};
      ppst_pkg::REG_LOOKAHEAD_MAX:     prdata = {9'd0, lookahead_max};
      ppst_pkg::REG_VEHICLE_LENGTH:    prdata = {9'd0, vehicle_length};
      ppst_pkg::REG_FORWARD_OFFSET:    prdata = 32'(forward_offset);
      ppst_pkg::REG_DISTANCE_MARGIN:   prdata = {9'd0, distance_margin};
      default:                         prdata = '0;
    endcase
  end

  // look-ahead clamp: min wins when the request is below it, even if min > max
  always_comb begin
    if (lookahead_request < lookahead_min) begin
      cfg.lfd = lookahead_min;
    end else if (lookahead_request > lookahead_max) begin
      cfg.lfd = lookahead_max;
    end else begin
      cfg.lfd = lookahead_request;
    end
    cfg.vehicle_length  = vehicle_length;
    cfg.forward_offset  = forward_offset;
    cfg.distance_margin = distance_margin;
  end

  // datapath; holds one result transaction in its output register
  ppst_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .px        (point_x),
    .py        (point_y),
    .plast     (last_point),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .angle     (steer_angle),
    .found_out (point_found),
    .dist_out  (tracked_distance)
  );

endmodule

### hw/rtl/ppst_checker.sv
// ----------------------------------------------------------------------------
// ppst_checker: port level checks for pure pursuit steering
// Watches the item and result transactions and the reported angle.
// ----------------------------------------------------------------------------
module ppst_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [ppst_pkg::ANGLE_W-1:0] steer_angle,
  input logic                                point_found
);

  // a pending result transaction holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(steer_angle))
    else $error("result dropped or changed while stalled");

  // an accepted item keeps the block busy for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted in back to back cycles");

  // no look-ahead point means straight ahead
  a_not_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && !point_found |-> steer_angle == '0)
    else $error("nonzero angle without a look-ahead point");

  // angle stays inside the clamp
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> steer_angle <= ppst_pkg::ANGLE_LIMIT &&
                  steer_angle >= -ppst_pkg::ANGLE_LIMIT)
    else $error("angle outside limit");

  // nothing pending right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result pending after reset");

endmodule

bind pure_pursuit_steering ppst_checker u_ppst_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .steer_angle (steer_angle),
  .point_found (point_found)
);

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: pure pursuit steering
// Drives waypoint lists with random valid/ready gaps, predicts the steering
// result of each closing waypoint and checks it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  typedef logic signed [ppst_pkg::COORD_W-1:0] coord_t;

  typedef struct packed {
    logic signed [ppst_pkg::COORD_W-1:0] x;
    logic signed [ppst_pkg::COORD_W-1:0] y;
    logic                                last;
  } waypoint_t;

  typedef struct packed {
    logic signed [ppst_pkg::ANGLE_W-1:0] angle;
    logic                                found;
    logic [ppst_pkg::DIST_W-1:0]         track_dist;
  } steer_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_ready;
  logic signed [ppst_pkg::COORD_W-1:0] point_x = '0, point_y = '0;
  logic last_point = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [ppst_pkg::ANGLE_W-1:0] steer_angle;
  logic point_found;
  logic [ppst_pkg::DIST_W-1:0] tracked_distance;

  pure_pursuit_steering i_dut (.*);

  // shadow configuration and search state
  logic [ppst_pkg::CFG_W-1:0] m_request = 32768, m_min = 19661, m_max = 111411;
  logic [ppst_pkg::CFG_W-1:0] m_length = 22938, m_margin = 0;
  logic signed [ppst_pkg::COORD_W-1:0] m_offset = 32768;
  bit m_found = 0;
  longint m_dx = 0, m_dy = 0;
  longint unsigned m_dist = 0;

  waypoint_t pending_points[$];
  steer_t    expected_steer[$];
  int errors = 0;
  int send_idle = 28, recv_idle = 50;
  longint cycles = 0;

  // in_ready_q: the current transaction went through at the last rising edge
  logic in_ready_q = 0;

  initial forever #1 clk = ~clk;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned hypot_of(input longint dx, input longint dy);
    longint unsigned ax = dx < 0 ? -dx : dx;
    longint unsigned ay = dy < 0 ? -dy : dy;
    return int_sqrt(ax * ax + ay * ay);
  endfunction

  // vectoring-mode cordic, q2.30 accumulator rounded to q2.16
  function automatic longint steer_atan2(input longint y, input longint x);
    longint z = 0, xs, ys;
    if (y == 0) return 0;
    for (int i = 0; i < ppst_pkg::CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += longint'(ppst_pkg::atan_q30(5'(i)));
      end else begin
        x -= ys; y += xs; z -= longint'(ppst_pkg::atan_q30(5'(i)));
      end
    end
    z = (z + 8192) >>> 14;
    if (z > 102944) z = 102944;
    if (z < -102944) z = -102944;
    return z;
  endfunction

  // advance the search for one accepted waypoint
  task automatic steer_predict(input waypoint_t w);
    longint unsigned lfd, r, ay;
    longint s, angle;
    steer_t e;
    lfd = m_request < m_min ? m_min : (m_request > m_max ? m_max : m_request);
    if (!m_found) begin
      m_dx = longint'(w.x) + longint'(m_offset);
      m_dy = longint'(w.y);
      if (m_dx > 0) begin
        r = hypot_of(m_dx, m_dy);
        m_dist = r > 16777215 ? 16777215 : r;
        if (m_dist + m_margin >= lfd) m_found = 1;
      end
    end
    if (!w.last) return;
    angle = 0;
    if (m_found && m_dx > 0) begin
      r = hypot_of(m_dx, m_dy);
      ay = m_dy < 0 ? -m_dy : m_dy;
      s = longint'((ay << 16) / r);
      if (m_dy < 0) s = -s;
      angle = steer_atan2(2 * longint'(m_length) * s, longint'(lfd << 16));
    end
    e.angle = angle[ppst_pkg::ANGLE_W-1:0];
    e.found = m_found;
    e.track_dist = m_dist[ppst_pkg::DIST_W-1:0];
    expected_steer = {expected_steer, e};
    m_found = 0;
    m_dx = 0;
    m_dy = 0;
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_ready_q) begin
        if (pending_points.size() > 0 && $urandom_range(99) >= send_idle) begin
          waypoint_t w;
          w = pending_points.pop_front();
          in_valid <= 1;
          point_x <= w.x;
          point_y <= w.y;
          last_point <= w.last;
        end else begin
          in_valid <= 0;
        end
      end
      out_ready <= $urandom_range(99) >= recv_idle;
    end
  end

  // monitor: predicts on accepted inputs, checks accepted results
  always @(posedge clk) begin
    steer_t g, e;
    in_ready_q <= !rst && in_valid && in_ready;
    if (!rst) begin
      cycles++;
      if (in_valid && in_ready) begin
        steer_predict('{point_x, point_y, last_point});
      end
      if (out_valid && out_ready) begin
        g = '{steer_angle, point_found, tracked_distance};
        if (expected_steer.size() == 0) begin
          report("unexpected result", 0, 0);
        end else begin
          e = expected_steer.pop_front();
          if (g.angle !== e.angle) report("steer_angle", g.angle, e.angle);
          if (g.found !== e.found) report("point_found", g.found, e.found);
          if (g.track_dist !== e.track_dist) begin
            report("tracked_distance", g.track_dist, e.track_dist);
          end
        end
      end
      if (cycles > 3000000) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] v);
    @(negedge clk);
    psel <= 1; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v; penable <= 0;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      ppst_pkg::REG_LOOKAHEAD_REQUEST: m_request = v[ppst_pkg::CFG_W-1:0];
      ppst_pkg::REG_LOOKAHEAD_MIN:     m_min = v[ppst_pkg::CFG_W-1:0];
      ppst_pkg::REG_LOOKAHEAD_MAX:     m_max = v[ppst_pkg::CFG_W-1:0];
      ppst_pkg::REG_VEHICLE_LENGTH:    m_length = v[ppst_pkg::CFG_W-1:0];
      ppst_pkg::REG_FORWARD_OFFSET:    m_offset = v[ppst_pkg::COORD_W-1:0];
      ppst_pkg::REG_DISTANCE_MARGIN:   m_margin = v[ppst_pkg::CFG_W-1:0];
      default: ;
    endcase
  endtask

  // wait until all queued waypoints are taken and results drained
  task automatic drain;
    int guard = 0;
    while ((pending_points.size() > 0 || in_valid || expected_steer.size() > 0)
           && guard < 1000000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
  endtask

  function automatic coord_t rand_coord;
    case ($urandom_range(5))
      0: return 24'sh7fffff;
      1: return 24'sh800000;
      2: return $urandom_range(1, 0) ? 24'sd0 : -24'sd1;
      3: return 24'($urandom);
      default: return coord_t'($signed($urandom_range(600000)) - 300000);
    endcase
  endfunction

  // random lists, mostly short
  task automatic push_lists(input int n);
    int len;
    waypoint_t w;
    while (n > 0) begin
      len = $urandom_range(9) == 0 ? 1 : $urandom_range(8, 1);
      for (int k = 0; k < len && n > 0; k++) begin
        w.x = rand_coord();
        w.y = rand_coord();
        w.last = (k == len - 1) || (n == 1);
        pending_points = {pending_points, w};
        n--;
      end
    end
  endtask

  task automatic push_point(input int x, input int y, input bit l);
    waypoint_t w;
    w = '{coord_t'(x), coord_t'(y), l};
    pending_points = {pending_points, w};
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: extremes, not found, single-marker, items after a find
    push_point(8388607, 8388607, 1);
    push_point(-8388608, -8388608, 1);
    push_point(-8388608, 0, 0);
    push_point(65536, 0, 1);
    push_point(100000, -200000, 0);
    push_point(-50000, 999, 1);
    push_point(8388607, -8388608, 0);
    push_point(0, 0, 0);
    push_point(1, 1, 1);
    push_point(-32768, 5, 1);
    drain();

    // zero look-ahead, min above max, margin, negative offset
    reg_write(ppst_pkg::REG_LOOKAHEAD_REQUEST, 0);
    reg_write(ppst_pkg::REG_LOOKAHEAD_MIN, 0);
    reg_write(ppst_pkg::REG_LOOKAHEAD_MAX, 32'h7fffff);
    reg_write(ppst_pkg::REG_VEHICLE_LENGTH, 32'h7fffff);
    reg_write(ppst_pkg::REG_FORWARD_OFFSET, 32'hff800000);
    reg_write(ppst_pkg::REG_DISTANCE_MARGIN, 32'h7fffff);
    push_point(8388607, 100, 1);
    push_point(8388607, 0, 1);
    push_point(8388607, -8388608, 1);
    drain();
    reg_write(ppst_pkg::REG_LOOKAHEAD_REQUEST, 10);
    reg_write(ppst_pkg::REG_LOOKAHEAD_MIN, 500000);
    reg_write(ppst_pkg::REG_LOOKAHEAD_MAX, 1000);
    reg_write(ppst_pkg::REG_DISTANCE_MARGIN, 0);
    reg_write(ppst_pkg::REG_FORWARD_OFFSET, 32'h7fffff);
    push_point(-8388608, 300000, 0);
    push_point(0, -300000, 1);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = phase == 0 ? 28 : (phase == 1 ? 50 : 0);
      recv_idle = phase == 0 ? 50 : (phase == 1 ? 28 : 0);
      reg_write(ppst_pkg::REG_LOOKAHEAD_REQUEST, $urandom_range(400000));
      reg_write(ppst_pkg::REG_LOOKAHEAD_MIN, $urandom_range(100000));
      reg_write(ppst_pkg::REG_LOOKAHEAD_MAX,
                $urandom_range(phase == 2 ? 1000 : 8388607));
      reg_write(ppst_pkg::REG_VEHICLE_LENGTH,
                $urandom_range(phase == 1 ? 8388607 : 200000));
      reg_write(ppst_pkg::REG_FORWARD_OFFSET, $urandom_range(131072) - 65536);
      reg_write(ppst_pkg::REG_DISTANCE_MARGIN,
                phase == 1 ? $urandom_range(8388607) : 0);
      push_lists(500);
      drain();
    end

    if (errors == 0 && expected_steer.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
